/* hw/rtl/chunk_filename_parser_core_assert.svh */
// Assertion macros used by the checker file
`ifndef CHUNK_FILENAME_PARSER_CORE_ASSERT_SVH
`define CHUNK_FILENAME_PARSER_CORE_ASSERT_SVH

// Property must hold on every rising clock edge outside reset
`define CFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define CFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cfp_pkg.sv */
// ----------------------------------------------------------------------------
// cfp_pkg
// Types and constants of the chunk file name parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfp_pkg;

  localparam int unsigned IdDigits  = 16;
  localparam int unsigned VerDigits = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 6;

  localparam logic [CfgIdxW-1:0] CfgEcDataMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgEcDataMax   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEcParityMin = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEcParityMax = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgXorLevelMin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgXorLevelMax = 3'd5;

  localparam logic [1:0] KindStd = 2'd0;
  localparam logic [1:0] KindEc  = 2'd1;
  localparam logic [1:0] KindXor = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic        format;
    logic [1:0]  kind;
    logic [5:0]  data_count;
    logic [5:0]  parity_count;
    logic [5:0]  part_num;
    logic [3:0]  xlevel;
    logic [3:0]  xpart;
    logic        xor_parity;
    logic [63:0] chunk_id;
    logic [31:0] version;
  } out_word_t;

  typedef struct packed {
    logic [5:0] ec_data_min;
    logic [5:0] ec_data_max;
    logic [5:0] ec_parity_min;
    logic [5:0] ec_parity_max;
    logic [3:0] xlevel_min;
    logic [3:0] xlevel_max;
  } cfg_t;

endpackage

/* hw/rtl/cfp_stream_if.sv */
// ----------------------------------------------------------------------------
// cfp_stream_if
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cfp_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/chunk_filename_parser_core.sv */
// ----------------------------------------------------------------------------
// chunk_filename_parser_core
// Byte-serial checker for chunk file names; one result per name.
// ----------------------------------------------------------------------------
// The result word is registered and appears in the cycle after the last byte is
// taken. Throughput: one byte per cycle, save for the input stall described below.
// The output register frees itself when taken, so input stalls only while a
// result waits unread. Reset clears parse state and loads register defaults.
`timescale 1ns / 1ps

module chunk_filename_parser_core
  import cfp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  cfp_stream_if.sink          in_if,
  cfp_stream_if.source        out_if
);

  typedef enum logic [4:0] {
    StChunk, StType, StEcLit, StEcSel, StEc2Lit, StEcPart, StOfLit, StEcData,
    StEcPar, StXorLit, StXSel, StXParLit, StXPart, StXLevel, StId, StVer,
    StExt, StLiz, StMfs, StDone
  } st_e;

  cfg_t cfg_q;
  st_e  st_q, st_d;
  logic [3:0] lpos_q, lpos_d;
  logic [7:0] acc_q, acc_d;
  logic [4:0] dcnt_q, dcnt_d;
  logic fail_q, fail_d;
  logic [1:0] kind_q, kind_d;
  logic fmt_q, fmt_d;
  logic [5:0] part_q, part_d, data_q, data_d, par_q, par_d;
  logic [3:0] lvl_q, lvl_d, xpart_q, xpart_d;
  logic xpar_q, xpar_d;
  logic [63:0] id_q, id_d;
  logic [31:0] ver_q, ver_d;
  logic       ovalid_q;
  out_word_t  oword_q, oword_d;
  logic       take;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{6'd2, 6'd32, 6'd1, 6'd32, 4'd2, 4'd9};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEcDataMin:   cfg_q.ec_data_min   <= cfg_data_i;
        CfgEcDataMax:   cfg_q.ec_data_max   <= cfg_data_i;
        CfgEcParityMin: cfg_q.ec_parity_min <= cfg_data_i;
        CfgEcParityMax: cfg_q.ec_parity_max <= cfg_data_i;
        CfgXorLevelMin: cfg_q.xlevel_min    <= cfg_data_i[3:0];
        CfgXorLevelMax: cfg_q.xlevel_max    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_if.ready = !ovalid_q || out_if.ready;
  assign take = in_if.valid && in_if.ready;
  assign out_if.valid = ovalid_q;
  assign out_if.data = oword_q;

  // Expected literal byte for the current state and position
  function automatic logic [7:0] lit_char(st_e s, logic [3:0] p);
    logic [7:0] r;
    r = 8'h00;
    case (s)
      StChunk: case (p)
        4'd0: r = "c"; 4'd1: r = "h"; 4'd2: r = "u";
        4'd3: r = "n"; 4'd4: r = "k"; 4'd5: r = "_"; default: r = 8'h00;
      endcase
      StEcLit: r = (p == 4'd1) ? "c" : 8'h00;
      StEc2Lit: r = (p == 4'd3) ? "_" : 8'h00;
      StOfLit, StXorLit: case (p)
        4'd0: r = "_"; 4'd1: r = (s == StOfLit) ? "o" : "o";
        4'd2: r = (s == StOfLit) ? "f" : "r"; 4'd3: r = "_"; default: r = 8'h00;
      endcase
      StXParLit: case (p)
        4'd1: r = "a"; 4'd2: r = "r"; 4'd3: r = "i"; 4'd4: r = "t";
        4'd5: r = "y"; 4'd6: r = "_"; 4'd7: r = "o"; 4'd8: r = "f";
        4'd9: r = "_"; default: r = 8'h00;
      endcase
      StLiz: case (p)
        4'd1: r = "i"; 4'd2: r = "z"; default: r = 8'h00;
      endcase
      StMfs: case (p)
        4'd1: r = "f"; 4'd2: r = "s"; default: r = 8'h00;
      endcase
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] lit_len(st_e s);
    case (s)
      StChunk: return 4'd6;
      StEcLit: return 4'd2;
      StXParLit: return 4'd10;
      StLiz, StMfs: return 4'd3;
      default: return 4'd4;
    endcase
  endfunction

  logic [7:0] c;
  logic       is_dig, is_hex;
  logic [3:0] hexv;
  logic [11:0] mul;
  logic [7:0] pm1;
  logic [6:0] dpsum;
  st_e        sx;
  logic       lit_st;

  // Per-byte parse step
  always_comb begin
    c = in_if.data.char_in;
    st_d = st_q; lpos_d = lpos_q; acc_d = acc_q; dcnt_d = dcnt_q;
    fail_d = fail_q; kind_d = kind_q; fmt_d = fmt_q; part_d = part_q;
    data_d = data_q; par_d = par_q; lvl_d = lvl_q; xpart_d = xpart_q;
    xpar_d = xpar_q; id_d = id_q; ver_d = ver_q;
    is_dig = (c >= "0") && (c <= "9");
    is_hex = is_dig || ((c >= "A") && (c <= "F"));
    hexv = is_dig ? c[3:0] : 4'(c[3:0] + 4'd9);
    mul = 12'(acc_q) * 12'd10 + 12'(c[3:0]);
    pm1 = acc_q - 8'd1;
    dpsum = 7'(data_q) + 7'(acc_q);
    // type selector falls through to the id digits
    sx = st_q;
    if (st_q == StType && c != "e" && c != "x") sx = StId;
    if (st_q == StXSel && c != "p") sx = StXPart;
    lit_st = (sx == StChunk) || (sx == StEcLit) || (sx == StEc2Lit) || (sx == StOfLit)
          || (sx == StXorLit) || (sx == StXParLit) || (sx == StLiz) || (sx == StMfs);
    if (!fail_q) begin
      if (sx != st_q) st_d = sx;
      if (lit_st) begin
        if (lpos_q >= lit_len(sx) || c != lit_char(sx, lpos_q)) begin
          fail_d = 1'b1;
        end else if (lpos_q + 4'd1 == lit_len(sx)) begin
          lpos_d = '0;
          case (sx)
            StChunk: st_d = StType;
            StEcLit: st_d = StEcSel;
            StEc2Lit: st_d = StEcPart;
            StOfLit: st_d = (kind_q == KindEc) ? StEcData : StXLevel;
            StXorLit: st_d = StXSel;
            StXParLit: st_d = StXLevel;
            default: st_d = StDone;
          endcase
        end else begin
          lpos_d = lpos_q + 4'd1;
        end
      end else begin
        case (sx)
          StType: begin
            lpos_d = 4'd1;
            if (c == "e") begin kind_d = KindEc; st_d = StEcLit; end
            else begin kind_d = KindXor; st_d = StXorLit; end
          end
          StEcSel: begin
            if (c == "_") st_d = StEcPart;
            else if (c == "2") begin st_d = StEc2Lit; lpos_d = 4'd3; end
            else fail_d = 1'b1;
          end
          StXSel: begin
            xpar_d = 1'b1; st_d = StXParLit; lpos_d = 4'd1;
          end
          StEcPart, StEcData, StEcPar, StXPart, StXLevel: begin
            if (is_dig) begin
              if (dcnt_q == 5'd0 && c[3:0] == 4'd0) fail_d = 1'b1;
              else if ((sx == StXPart || sx == StXLevel) && dcnt_q >= 5'd2)
                fail_d = 1'b1;
              else begin
                acc_d = (mul > 12'd255) ? 8'd255 : mul[7:0];
                if (dcnt_q < 5'd31) dcnt_d = dcnt_q + 5'd1;
              end
            end else if (c == "_" && dcnt_q != 5'd0) begin
              acc_d = '0; dcnt_d = '0;
              case (sx)
                StEcPart: begin
                  if (pm1 > 8'd63 || acc_q == 8'd0) fail_d = 1'b1;
                  else begin part_d = pm1[5:0]; st_d = StOfLit; lpos_d = 4'd1; end
                end
                StEcData: begin
                  if (acc_q < 8'(cfg_q.ec_data_min) || acc_q > 8'(cfg_q.ec_data_max))
                    fail_d = 1'b1;
                  else begin data_d = acc_q[5:0]; st_d = StEcPar; end
                end
                StEcPar: begin
                  if (acc_q < 8'(cfg_q.ec_parity_min) || acc_q > 8'(cfg_q.ec_parity_max)
                      || 7'(part_q) >= dpsum)
                    fail_d = 1'b1;
                  else begin par_d = acc_q[5:0]; st_d = StId; end
                end
                StXPart: begin
                  if (acc_q > 8'd15) fail_d = 1'b1;
                  else begin xpart_d = acc_q[3:0]; st_d = StOfLit; lpos_d = 4'd1; end
                end
                default: begin
                  if (acc_q < 8'(cfg_q.xlevel_min) || acc_q > 8'(cfg_q.xlevel_max)
                      || (!xpar_q && 8'(xpart_q) > acc_q))
                    fail_d = 1'b1;
                  else begin lvl_d = acc_q[3:0]; st_d = StId; end
                end
              endcase
            end else fail_d = 1'b1;
          end
          StId: begin
            if (is_hex) begin
              if (dcnt_q >= 5'(IdDigits)) fail_d = 1'b1;
              else begin id_d = {id_q[59:0], hexv}; dcnt_d = dcnt_q + 5'd1; end
            end else if (c == "_" && dcnt_q == 5'(IdDigits)) begin
              dcnt_d = '0; st_d = StVer;
            end else fail_d = 1'b1;
          end
          StVer: begin
            if (is_hex) begin
              if (dcnt_q >= 5'(VerDigits)) fail_d = 1'b1;
              else begin ver_d = {ver_q[27:0], hexv}; dcnt_d = dcnt_q + 5'd1; end
            end else if (c == "." && dcnt_q == 5'(VerDigits)) begin
              dcnt_d = '0; st_d = StExt;
            end else fail_d = 1'b1;
          end
          StExt: begin
            lpos_d = 4'd1;
            if (c == "l") st_d = StLiz;
            else if (c == "m") begin fmt_d = 1'b1; st_d = StMfs; end
            else fail_d = 1'b1;
          end
          default: fail_d = 1'b1;
        endcase
      end
    end
    // result word from the post-step state
    oword_d = '0;
    if (!fail_d && st_d == StDone) begin
      oword_d.valid_res = 1'b1;
      oword_d.format = fmt_d;
      oword_d.kind = kind_d;
      oword_d.data_count = data_d;
      oword_d.parity_count = par_d;
      oword_d.part_num = part_d;
      oword_d.xlevel = lvl_d;
      oword_d.xpart = xpar_d ? 4'd0 : xpart_d;
      oword_d.xor_parity = xpar_d;
      oword_d.chunk_id = id_d;
      oword_d.version = ver_d;
    end
  end

  // Parse state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StChunk; lpos_q <= '0; acc_q <= '0; dcnt_q <= '0; fail_q <= 1'b0;
      kind_q <= '0; fmt_q <= 1'b0; part_q <= '0; data_q <= '0; par_q <= '0;
      lvl_q <= '0; xpart_q <= '0; xpar_q <= 1'b0; id_q <= '0; ver_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= (take && in_if.data.is_last) || (ovalid_q && !out_if.ready);
      if (take) begin
        if (in_if.data.is_last) begin
          st_q <= StChunk; lpos_q <= '0; acc_q <= '0; dcnt_q <= '0; fail_q <= 1'b0;
          kind_q <= '0; fmt_q <= 1'b0; part_q <= '0; data_q <= '0; par_q <= '0;
          lvl_q <= '0; xpart_q <= '0; xpar_q <= 1'b0; id_q <= '0; ver_q <= '0;
        end else begin
          st_q <= st_d; lpos_q <= lpos_d; acc_q <= acc_d; dcnt_q <= dcnt_d;
          fail_q <= fail_d; kind_q <= kind_d; fmt_q <= fmt_d; part_q <= part_d;
          data_q <= data_d; par_q <= par_d; lvl_q <= lvl_d; xpart_q <= xpart_d;
          xpar_q <= xpar_d; id_q <= id_d; ver_q <= ver_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_if.data.is_last) oword_q <= oword_d;
  end

endmodule

/* hw/rtl/cfp_checker.sv */
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks of the chunk file name parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chunk_filename_parser_core_assert.svh"

module cfp_checker
  import cfp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // result only after a last byte
  `CFP_ASSERT_NEXT(a_res_after_last, !(in_valid && in_ready && in_data.is_last) && !(out_valid && !out_ready), !out_valid, "result without last byte")
  // last byte produces a result
  `CFP_ASSERT_NEXT(a_last_gives_res, in_valid && in_ready && in_data.is_last, out_valid, "missing result")
  // invalid result carries a zero chunk id
  `CFP_ASSERT(a_zero_fields, !(out_valid && !out_data.valid_res) || out_data.chunk_id == 64'd0, "invalid result has id")
  // stalled result holds
  `CFP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

endmodule

bind chunk_filename_parser_core cfp_checker u_cfp_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .in_valid(in_if.valid), .in_ready(in_if.ready), .in_data(in_if.data),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);

/* verif/chunk_filename_parser_core_test.sv */
// ----------------------------------------------------------------------------
// chunk_filename_parser_core_test
// Self-checking bench: streams chunk file names byte by byte into the parser,
// predicts the result word of each name and compares it with the word taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunk_filename_parser_core_test;
  import cfp_pkg::*;

  typedef enum logic [4:0] {
    PsChunk, PsType, PsEcLit, PsEcSel, PsEc2Lit, PsEcPart, PsOfLit, PsEcData,
    PsEcPar, PsXorLit, PsXSel, PsXParLit, PsXPart, PsXLevel, PsId, PsVer,
    PsExt, PsLiz, PsMfs, PsDone
  } parse_st_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  cfp_stream_if #(.T(in_word_t))  byte_if ();
  cfp_stream_if #(.T(out_word_t)) res_if ();

  chunk_filename_parser_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(byte_if.sink), .out_if(res_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  // predictor state
  cfg_t cfg;
  parse_st_e ps;
  int lit_pos, acc, ndig;
  bit bad, fmt, xpar;
  logic [1:0] knd;
  int prt, dat, par, lvl, xprt;
  logic [63:0] cid;
  logic [31:0] ver;
  out_word_t results_due[$];
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit hold_res = 1'b0;

  function automatic int hexval(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void clear_name();
    ps = PsChunk; lit_pos = 0; acc = 0; ndig = 0; bad = 0;
    knd = KindStd; fmt = 0; prt = 0; dat = 0; par = 0; lvl = 0;
    xprt = 0; xpar = 0; cid = '0; ver = '0;
  endfunction

  function automatic void match_lit(string s, logic [7:0] c, parse_st_e nxt);
    if (lit_pos >= s.len() || c != s[lit_pos]) begin
      bad = 1; return;
    end
    lit_pos++;
    if (lit_pos == s.len()) begin
      lit_pos = 0; ps = nxt;
    end
  endfunction

  function automatic void close_number();
    int v;
    v = acc;
    case (ps)
      PsEcPart: begin
        if (v < 1 || v > 64) begin bad = 1; return; end
        prt = v - 1; ps = PsOfLit; lit_pos = 1;
      end
      PsEcData: begin
        if (v < cfg.ec_data_min || v > cfg.ec_data_max) begin bad = 1; return; end
        dat = v; ps = PsEcPar;
      end
      PsEcPar: begin
        if (v < cfg.ec_parity_min || v > cfg.ec_parity_max) begin
          bad = 1; return;
        end
        par = v;
        if (prt >= dat + par) begin bad = 1; return; end
        ps = PsId;
      end
      PsXPart: begin
        if (v > 15) begin bad = 1; return; end
        xprt = v; ps = PsOfLit; lit_pos = 1;
      end
      default: begin
        if (v < cfg.xlevel_min || v > cfg.xlevel_max) begin
          bad = 1; return;
        end
        if (!xpar && xprt > v) begin bad = 1; return; end
        lvl = v; ps = PsId;
      end
    endcase
    acc = 0; ndig = 0;
  endfunction

  function automatic void number_byte(logic [7:0] c);
    bit is_x;
    int d;
    is_x = (ps == PsXPart || ps == PsXLevel);
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      if (ndig == 0 && d == 0) begin bad = 1; return; end
      if (is_x && ndig >= 2) begin bad = 1; return; end
      acc = acc * 10 + d;
      if (acc > 255) acc = 255;
      if (ndig < 31) ndig++;
    end else if (c == "_" && ndig > 0) close_number();
    else bad = 1;
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    int h;
    case (ps)
      PsChunk: match_lit("chunk_", c, PsType);
      PsType:
        if (c == "e") begin knd = KindEc; ps = PsEcLit; lit_pos = 1; end
        else if (c == "x") begin knd = KindXor; ps = PsXorLit; lit_pos = 1; end
        else begin ps = PsId; parse_byte(c); end
      PsEcLit: match_lit("ec", c, PsEcSel);
      PsEcSel:
        if (c == "_") ps = PsEcPart;
        else if (c == "2") begin ps = PsEc2Lit; lit_pos = 3; end
        else bad = 1;
      PsEc2Lit: match_lit("ec2_", c, PsEcPart);
      PsOfLit: match_lit("_of_", c, knd == KindEc ? PsEcData : PsXLevel);
      PsXorLit: match_lit("xor_", c, PsXSel);
      PsXSel:
        if (c == "p") begin xpar = 1; ps = PsXParLit; lit_pos = 1; end
        else begin ps = PsXPart; number_byte(c); end
      PsXParLit: match_lit({"parity", "_of_"}, c, PsXLevel);
      PsEcPart, PsEcData, PsEcPar, PsXPart, PsXLevel: number_byte(c);
      PsId: begin
        h = hexval(c);
        if (h >= 0) begin
          if (ndig >= IdDigits) begin bad = 1; return; end
          cid = {cid[59:0], 4'(h)}; ndig++;
        end else if (c == "_" && ndig == IdDigits) begin
          ndig = 0; ps = PsVer;
        end else bad = 1;
      end
      PsVer: begin
        h = hexval(c);
        if (h >= 0) begin
          if (ndig >= VerDigits) begin bad = 1; return; end
          ver = {ver[27:0], 4'(h)}; ndig++;
        end else if (c == "." && ndig == VerDigits) begin
          ndig = 0; ps = PsExt;
        end else bad = 1;
      end
      PsExt:
        if (c == "l") begin ps = PsLiz; lit_pos = 1; end
        else if (c == "m") begin fmt = 1; ps = PsMfs; lit_pos = 1; end
        else bad = 1;
      PsLiz: match_lit("liz", c, PsDone);
      PsMfs: match_lit("mfs", c, PsDone);
      default: bad = 1;
    endcase
  endfunction

  // Advance the predictor by one accepted byte; queue a result on the last one.
  function automatic void predict_byte(in_word_t w);
    out_word_t r;
    if (!bad) parse_byte(w.char_in);
    if (!w.is_last) return;
    r = '0;
    if (!bad && ps == PsDone) begin
      r.valid_res = 1; r.format = fmt; r.kind = knd;
      r.data_count = dat[5:0]; r.parity_count = par[5:0]; r.part_num = prt[5:0];
      r.xlevel = lvl[3:0]; r.xpart = xpar ? 4'd0 : xprt[3:0];
      r.xor_parity = xpar; r.chunk_id = cid; r.version = ver;
    end
    results_due.push_back(r);
    clear_name();
  endfunction

  // Result side: random stalls, one long hold-off, and the compare.
  // Handshake signals only change at the rising edge, so the word seen at the
  // falling edge with valid and ready high is the one taken at the next edge.
  initial begin
    out_word_t e;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      res_if.ready <= !hold_res && !(idle_on && $urandom_range(99) < 15);
      @(negedge clk_i);
      if (res_if.valid && res_if.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word %h", res_if.data);
        end else begin
          e = results_due.pop_front();
          if (res_if.data !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", e, res_if.data);
          end
        end
      end
    end
  end

  // drive one word and wait until it is taken
  task automatic send_byte(logic [7:0] c, bit last);
    while (idle_on && $urandom_range(99) < 15) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    byte_if.valid <= 1'b1;
    byte_if.data <= '{char_in: c, is_last: last};
    @(negedge clk_i);
    while (!byte_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    predict_byte('{char_in: c, is_last: last});
  endtask

  task automatic send_name(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [5:0] val);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgEcDataMin: cfg.ec_data_min = val;
      CfgEcDataMax: cfg.ec_data_max = val;
      CfgEcParityMin: cfg.ec_parity_min = val;
      CfgEcParityMax: cfg.ec_parity_max = val;
      CfgXorLevelMin: cfg.xlevel_min = val[3:0];
      default: cfg.xlevel_max = val[3:0];
    endcase
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic string hex_str(int n, bit lower);
    string s, d;
    s = "";
    d = lower ? "0123456789abcdef" : "0123456789ABCDEF";
    for (int i = 0; i < n; i++) s = {s, string'(d[$urandom_range(15)])};
    return s;
  endfunction

  function automatic string dec_str(int v);
    return $sformatf("%0d", v);
  endfunction

  // well-formed-ish name with random content
  function automatic string rand_name();
    string s, ty;
    int k;
    k = $urandom_range(2);
    case (k)
      0: ty = "";
      1: ty = $sformatf("%s%0d_of_%0d_%0d_", $urandom_range(1) ? "ec2_" : "ec_",
                        $urandom_range(1, 70), $urandom_range(1, 40),
                        $urandom_range(1, 40));
      default:
        if ($urandom_range(2) == 0)
          ty = $sformatf("xor_parity%s%0d_", "_of_", $urandom_range(1, 16));
        else ty = $sformatf("xor_%0d_of_%0d_", $urandom_range(1, 17), $urandom_range(1, 16));
    endcase
    s = {"chunk_", ty, hex_str(16, 0), "_", hex_str(8, 0),
         $urandom_range(1) ? ".mfs" : ".liz"};
    return s;
  endfunction

  // directed names; expected word typed in where it is obvious
  typedef struct {
    string nm;
    bit    typed;
    out_word_t res;
  } dir_row_t;

  dir_row_t dir_rows[$];
  out_word_t ok_std;

  initial begin
    string s;
    int pos;
    byte_if.valid <= 1'b0;
    byte_if.data <= '0;
    clear_name();
    cfg = '{6'd2, 6'd32, 6'd1, 6'd32, 4'd2, 4'd9};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ok_std = '0; ok_std.valid_res = 1;
    ok_std.chunk_id = 64'hFFFFFFFFFFFFFFFF; ok_std.version = 32'hFFFFFFFF;
    dir_rows.push_back('{"chunk_FFFFFFFFFFFFFFFF_FFFFFFFF.liz", 1, ok_std});
    ok_std.chunk_id = '0; ok_std.version = '0; ok_std.format = 1;
    dir_rows.push_back('{"chunk_0000000000000000_00000000.mfs", 1, ok_std});
    dir_rows.push_back('{"chunk_ec_64_of_32_32_123456789ABCDEF0_CAFEF00D.mfs", 0, '0});
    dir_rows.push_back('{"chunk_ec_65_of_32_32_123456789ABCDEF0_CAFEF00D.mfs", 1, '0});
    dir_rows.push_back('{"chunk_ec_4_of_2_1_0000000000000000_00000000.liz", 1, '0});
    dir_rows.push_back('{"chunk_ec_999_of_2_1_0000000000000000_00000000.liz", 1, '0});
    dir_rows.push_back('{"chunk_ec_01_of_2_1_0000000000000000_00000000.liz", 1, '0});
    dir_rows.push_back('{"chunk_xor_16_of_9_0000000000000001_00000001.liz", 1, '0});
    dir_rows.push_back('{"chunk_xor_100_of_9_0000000000000001_00000001.liz", 1, '0});
    dir_rows.push_back('{"chunk_xor_3_of_2_0000000000000001_00000001.liz", 1, '0});
    dir_rows.push_back('{{"chunk_xor_parity", "_of_10_0000000000000001_00000001.liz"},
                         1, '0});
    dir_rows.push_back('{"chunk_abcdef0123456789_00000000.liz", 1, '0});
    dir_rows.push_back('{"chunk_0000000000000000_00000000.lizX", 1, '0});
    dir_rows.push_back('{"chunk_0000000000000000_0000", 1, '0});
    dir_rows.push_back('{"chunk_00000000000000000_00000000.liz", 1, '0});
    dir_rows.push_back('{"chunk_ec2x", 1, '0});
    dir_rows.push_back('{"c", 1, '0});

    foreach (dir_rows[i]) begin
      send_name(dir_rows[i].nm);
      if (dir_rows[i].typed && results_due[$] !== dir_rows[i].res) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d: prediction disagrees", i);
      end
    end
    // bytes outside printable ASCII, including one with every bit of char_in set
    send_byte(8'hFF, 0); send_byte(8'h80, 0); send_byte(8'h00, 1);
    drain();

    // register extremes: min above max, then widest ranges
    write_reg(CfgEcDataMin, 6'd63); write_reg(CfgEcDataMax, 6'd1);
    write_reg(CfgXorLevelMin, 6'd15); write_reg(CfgXorLevelMax, 6'd1);
    send_name("chunk_ec_1_of_2_1_0000000000000000_00000000.liz");
    send_name("chunk_xor_1_of_5_0000000000000000_00000000.liz");
    drain();
    write_reg(CfgEcDataMin, 6'd1); write_reg(CfgEcDataMax, 6'd63);
    write_reg(CfgEcParityMin, 6'd1); write_reg(CfgEcParityMax, 6'd63);
    write_reg(CfgXorLevelMin, 6'd1); write_reg(CfgXorLevelMax, 6'd15);
    send_name("chunk_ec_64_of_63_63_0000000000000000_00000000.liz");
    send_name("chunk_xor_15_of_15_0000000000000000_00000000.mfs");

    // back-pressure: hold results while bytes keep coming
    fork
      begin
        hold_res = 1;
        repeat (60) @(posedge clk_i);
        hold_res = 0;
      end
      for (int n = 0; n < 3; n++) send_name("chunk_0000000000000000_00000000.liz");
    join

    // random phases over two register settings
    for (int ph = 0; ph < 2; ph++) begin
      drain();
      write_reg(CfgEcDataMin, 6'($urandom_range(1, 8)));
      write_reg(CfgEcDataMax, 6'($urandom_range(8, 63)));
      write_reg(CfgEcParityMin, 6'($urandom_range(1, 8)));
      write_reg(CfgEcParityMax, 6'($urandom_range(8, 63)));
      write_reg(CfgXorLevelMin, 6'($urandom_range(1, 5)));
      write_reg(CfgXorLevelMax, 6'($urandom_range(5, 15)));
      idle_on = (ph != 1);
      pos = 0;
      while (pos < 100) begin
        s = rand_name();
        if ($urandom_range(9) == 0) begin
          // corrupt one byte or cut the name short
          if ($urandom_range(1)) s = s.substr(0, $urandom_range(s.len() - 1));
          else s[$urandom_range(s.len() - 1)] = 8'($urandom_range(255));
        end
        if ($urandom_range(19) == 0) s = {s, hex_str(1, 1)};
        send_name(s);
        pos += s.len();
      end
    end
    idle_on = 1;
    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/cfp_pkg.sv
hw/rtl/cfp_stream_if.sv
hw/rtl/chunk_filename_parser_core.sv
hw/rtl/cfp_checker.sv
verif/chunk_filename_parser_core_test.sv
